// ===== src/lltc_pkg.sv =====
// Shared types and constants for the LRU line tag cache.
// No dependencies; imported by the controller, datapath and top level.
package lltc_pkg;

   // Word address width is fixed by the access format.
   localparam int ADDR_W = 7;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the line start of a new access
      logic update;   // compare, reorder the list and issue the result
   } dp_cmd_type;

endpackage

// ===== src/lltc_ctrl.sv =====
// Controller state machine for the LRU line tag cache.
// Depends on lltc_pkg for the state enum and the command struct.
module lltc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output lltc_pkg::dp_cmd_type cmd
);
   import lltc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = start ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      cmd.load   = 1'b0;
      cmd.update = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_LOOKUP: begin
            busy       = 1'b1;
            cmd.update = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/lltc_datapath.sv =====
// Datapath for the LRU line tag cache: line start table, tag list with
// valid bits, parallel compare, LRU reorder and result registers.
// Depends on lltc_pkg for the address width and the command struct.
module lltc_datapath #(
   parameter int NUM_LINES  = 5,
   parameter int LINE_WORDS = 12,
   parameter int MEM_WORDS  = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lltc_pkg::dp_cmd_type          cmd,
   input  logic [lltc_pkg::ADDR_W-1:0]  word_address,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [lltc_pkg::ADDR_W-1:0]  rsp_line_base,
   output logic                         rsp_evicted_valid,
   output logic [lltc_pkg::ADDR_W-1:0]  rsp_evicted_line
);
   import lltc_pkg::*;

   localparam int ADDR_SPAN = 1 << ADDR_W;

   // Constant table: wrapped address rounded down to its line start.
   logic [ADDR_W-1:0] start_lut [ADDR_SPAN];

   for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_lut
      localparam int LineStart = ((a % MEM_WORDS) / LINE_WORDS) * LINE_WORDS;
      assign start_lut[a] = ADDR_W'(LineStart);
   end

   logic [ADDR_W-1:0] tag_ff;
   logic [ADDR_W-1:0] line_tags_ff [NUM_LINES];
   logic [ADDR_W-1:0] line_tags_in [NUM_LINES];
   logic [NUM_LINES-1:0] tag_valid_ff;
   logic [NUM_LINES-1:0] tag_valid_in;
   logic [NUM_LINES-1:0] match;
   logic [NUM_LINES-1:0] shift_en;
   logic hit;
   logic evict;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [ADDR_W-1:0]   rsp_line_base_ff;
   logic                rsp_evicted_valid_ff;
   logic [ADDR_W-1:0]   rsp_evicted_line_ff;

   always_comb begin
      logic seen;
      for (int i = 0; i < NUM_LINES; i++) begin
         match[i] = tag_valid_ff[i] && (line_tags_ff[i] == tag_ff);
      end
      hit = |match;
      evict = !hit && tag_valid_ff[NUM_LINES-1];
      // An entry moves back when it sits at or before the hit, or on any miss.
      seen = 1'b0;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         seen        = seen | match[i];
         shift_en[i] = !hit || seen;
      end
      line_tags_in[0] = tag_ff;
      tag_valid_in[0] = 1'b1;
      for (int i = 1; i < NUM_LINES; i++) begin
         line_tags_in[i] = shift_en[i] ? line_tags_ff[i-1] : line_tags_ff[i];
         tag_valid_in[i] = shift_en[i] ? tag_valid_ff[i-1] : tag_valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff <= start_lut[word_address];
      end
      if (cmd.update) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            line_tags_ff[i] <= line_tags_in[i];
         end
         rsp_hit_ff           <= hit;
         rsp_line_base_ff     <= tag_ff;
         rsp_evicted_valid_ff <= evict;
         rsp_evicted_line_ff  <= evict ? line_tags_ff[NUM_LINES-1] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            tag_valid_ff <= tag_valid_in;
         end
         rsp_valid_ff <= cmd.update;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_line_base     = rsp_line_base_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_line  = rsp_evicted_line_ff;

endmodule

// ===== src/lru_line_tag_cache_top.sv =====
// Top level of the LRU line tag cache: controller plus datapath.
// Depends on lltc_pkg, lltc_ctrl and lltc_datapath.
//
// Usage:
//   Drive req_word_address and raise start; the access transfers at the
//   rising edge where start is high and busy is low. busy then stays high
//   for one cycle while the tag list is compared and reordered.
//   One result per access appears on the rsp_ ports for exactly one cycle,
//   marked by rsp_valid, in the cycle after the lookup; it is taken at the
//   rising edge that ends that cycle. The receiver cannot stall; a result
//   is taken in the cycle it is shown. A new access is not accepted while
//   busy is high, since the controller's lookup state owns the tag list
//   for each access.
//   rsp_line_base is the wrapped address rounded down to a line start;
//   on a miss with a full list the oldest line is reported as evicted,
//   otherwise rsp_evicted_line reads zero.
//   Reset (synchronous, active high) clears the valid bits and the
//   controller; tags are left as they are and never read until written.
module lru_line_tag_cache_top #(
   parameter int NUM_LINES  = 5,
   parameter int LINE_WORDS = 12,
   parameter int MEM_WORDS  = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lltc_pkg::ADDR_W-1:0]  req_word_address,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [lltc_pkg::ADDR_W-1:0]  rsp_line_base,
   output logic                         rsp_evicted_valid,
   output logic [lltc_pkg::ADDR_W-1:0]  rsp_evicted_line
);
   import lltc_pkg::*;

   dp_cmd_type cmd;

   lltc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lltc_datapath #(
      .NUM_LINES  (NUM_LINES),
      .LINE_WORDS (LINE_WORDS),
      .MEM_WORDS  (MEM_WORDS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .word_address      (req_word_address),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_line_base     (rsp_line_base),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_line  (rsp_evicted_line)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted access did not enter lookup");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("lookup did not finish with a result");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a lookup");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (!rsp_evicted_valid && rsp_evicted_line == '0))
      else $error("hit reported an eviction");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for lru_line_tag_cache_top: address stream in, hit/evict results out.
// Depends on lltc_pkg and the top level; predicts the most-recent-first tag list in-house.
module tb_top;
   import lltc_pkg::*;

   localparam int NUM_LINES  = 5;
   localparam int LINE_WORDS = 12;
   localparam int MEM_WORDS  = 128;
   localparam int LINE_COUNT = (MEM_WORDS + LINE_WORDS - 1) / LINE_WORDS;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] line_base;
      logic              evicted_valid;
      logic [ADDR_W-1:0] evicted_line;
   } line_result_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [ADDR_W-1:0] req_word_address = '0;
   logic              busy;
   logic              rsp_valid;
   logic              rsp_hit;
   logic [ADDR_W-1:0] rsp_line_base;
   logic              rsp_evicted_valid;
   logic [ADDR_W-1:0] rsp_evicted_line;

   logic [ADDR_W-1:0] addr_queue[$];
   line_result_type   results_due[$];
   logic              took_addr = 1'b0;
   int                drive_count = 0;
   int                mismatch_count = 0;
   int                hit_count = 0;
   int                miss_count = 0;
   int                evict_count = 0;

   // predicted tag list, most recent first
   logic [ADDR_W-1:0] tag_list[NUM_LINES];
   logic              tag_live[NUM_LINES];

   lru_line_tag_cache_top #(
      .NUM_LINES (NUM_LINES),
      .LINE_WORDS(LINE_WORDS),
      .MEM_WORDS (MEM_WORDS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word_address (req_word_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_line_base    (rsp_line_base),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_line (rsp_evicted_line)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #400000;
      $display("%0t: run timed out", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Look up one access in the predicted list, reorder it and return the result.
   task automatic access_line_list(input logic [ADDR_W-1:0] addr,
                                   output line_result_type res);
      int                wrapped;
      int                base;
      int                where;
      int                i;
      logic              found;
      logic [ADDR_W-1:0] tag;
      wrapped = int'(addr) % MEM_WORDS;
      base    = (wrapped / LINE_WORDS) * LINE_WORDS;
      tag     = ADDR_W'(base);
      found   = 1'b0;
      where   = NUM_LINES - 1;
      res     = '0;
      for (i = 0; i < NUM_LINES; i++) begin
         if (!found && tag_live[i] && tag_list[i] == tag) begin
            found = 1'b1;
            where = i;
         end
      end
      if (!found && tag_live[NUM_LINES-1]) begin
         res.evicted_valid = 1'b1;
         res.evicted_line  = tag_list[NUM_LINES-1];
      end
      for (i = where; i > 0; i--) begin
         tag_list[i] = tag_list[i-1];
         tag_live[i] = tag_live[i-1];
      end
      tag_list[0]   = tag;
      tag_live[0]   = 1'b1;
      res.hit       = found;
      res.line_base = tag;
   endtask

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Pick an address inside a given line, clipped to the top of memory.
   function automatic logic [ADDR_W-1:0] addr_in_line(input int line_idx);
      int base;
      int span;
      base = line_idx * LINE_WORDS;
      span = (base + LINE_WORDS - 1 > MEM_WORDS - 1) ? MEM_WORDS - 1 - base : LINE_WORDS - 1;
      return ADDR_W'(base + $urandom_range(0, span));
   endfunction

   // Driver: hold an item until it transfers, then advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_addr) begin
         if (addr_queue.size() != 0 &&
             ((drive_count >= 300 && drive_count < 500) || $urandom_range(0, 99) >= 13)) begin
            start            <= 1'b1;
            req_word_address <= addr_queue.pop_front();
            drive_count      <= drive_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each strobed result, then predict any access taken at this edge.
   always @(posedge clock) begin : monitor
      line_result_type due;
      line_result_type got;
      int              i;
      if (reset) begin
         took_addr <= 1'b0;
         for (i = 0; i < NUM_LINES; i++) begin
            tag_live[i] = 1'b0;
         end
      end else begin
         took_addr <= start && !busy;
         if (rsp_valid) begin
            got = '{rsp_hit, rsp_line_base, rsp_evicted_valid, rsp_evicted_line};
            if (results_due.size() == 0) begin
               $display("%0t: result with nothing expected, actual %p", $time, got);
               mismatch_count++;
            end else begin
               due = results_due.pop_front();
               check_field("hit", ADDR_W'(due.hit), ADDR_W'(got.hit));
               check_field("line_base", due.line_base, got.line_base);
               check_field("evicted_valid", ADDR_W'(due.evicted_valid),
                           ADDR_W'(got.evicted_valid));
               check_field("evicted_line", due.evicted_line, got.evicted_line);
            end
         end
         if (start && !busy) begin
            access_line_list(req_word_address, due);
            results_due.push_back(due);
            if (due.hit) hit_count++;
            else miss_count++;
            if (due.evicted_valid) evict_count++;
         end
      end
   end

   initial begin : stimulus
      int work_set[8];
      int set_size;
      int n;
      int k;
      // directed: line edges, fill, evict, hits at front, middle and oldest slot
      addr_queue = '{7'd0, 7'd127, 7'd5, 7'd11, 7'd12, 7'd24, 7'd36, 7'd60, 7'd127, 7'd40,
                     7'd23, 7'd12, 7'd72, 7'd84, 7'd96, 7'd108, 7'd119, 7'd120, 7'd64,
                     7'd85, 7'd47, 7'd48, 7'd95, 7'd107};
      set_size = 5;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // rotate the working set so hits, reorders and evictions all stay frequent
         if (n % 60 == 0) begin
            set_size = $urandom_range(3, 8);
            for (k = 0; k < 8; k++) begin
               work_set[k] = $urandom_range(0, LINE_COUNT - 1);
            end
         end
         if ($urandom_range(0, 99) < 70) begin
            addr_queue.push_back(addr_in_line(work_set[$urandom_range(0, set_size - 1)]));
         end else begin
            addr_queue.push_back(ADDR_W'($urandom_range(0, MEM_WORDS - 1)));
         end
      end
      wait (!reset);
      while (addr_queue.size() != 0 || start) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("Covered %0d accesses: %0d hits, %0d misses, %0d evictions",
               hit_count + miss_count, hit_count, miss_count, evict_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== lru_line_tag_cache_top.f =====
src/lltc_pkg.sv
src/lltc_ctrl.sv
src/lltc_datapath.sv
src/lru_line_tag_cache_top.sv
tb/tb_top.sv
